// ===== rtl/uvpd_pkg.sv =====
// Package for the UV-from-position-differential pipeline.
// Holds the beat structs, the plane codes, the fixed-point constants and shared helpers.
// No dependencies.
package uvpd_pkg;

	// Fixed-point format of every input and output value.
	localparam int FRAC_BITS = 16;
	// Right shift that brings the numerator magnitude down to the first partial remainder.
	localparam int PRE_SHIFT = 32 - FRAC_BITS;
	// Number of quotient bits produced, one per divider step.
	localparam int QUO_BITS = 32;

	typedef enum logic [1:0] {
		PLANE_NONE = 2'd0,
		PLANE_XY   = 2'd1,
		PLANE_XZ   = 2'd2,
		PLANE_YZ   = 2'd3
	} plane_t;

	// One input beat.
	typedef struct packed {
		logic signed [31:0] delta_x;
		logic signed [31:0] delta_y;
		logic signed [31:0] delta_z;
		logic signed [31:0] u_tangent_x;
		logic signed [31:0] u_tangent_y;
		logic signed [31:0] u_tangent_z;
		logic signed [31:0] v_tangent_x;
		logic signed [31:0] v_tangent_y;
		logic signed [31:0] v_tangent_z;
	} in_beat_t;

	// One output beat.
	typedef struct packed {
		logic signed [31:0] u_change;
		logic signed [31:0] v_change;
		logic [1:0]         plane_used;
	} out_beat_t;

	// Cramer's rule terms handed from the front end to the divider.
	typedef struct packed {
		logic signed [63:0] num_u;
		logic signed [63:0] num_v;
		logic signed [63:0] den;
		plane_t             plane;
	} solve_t;

	// State of one quotient lane inside the divider.
	typedef struct packed {
		logic [63:0]         rem;
		logic [QUO_BITS-1:0] bits;
		logic [QUO_BITS-1:0] quo;
		logic                ovf;
		logic                neg;
	} lane_t;

	// Exact signed 32 x 32 product.
	function automatic logic signed [63:0] smul(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [63:0] wa;
		logic signed [63:0] wb;
		wa = 64'(a);
		wb = 64'(b);
		return wa * wb;
	endfunction

	// Magnitude of a signed 64-bit value as an unsigned 64-bit value.
	function automatic logic [63:0] mag64(logic signed [63:0] v);
		logic [63:0] r;
		if (v[63]) begin
			r = 64'(0) - 64'(v);
		end else begin
			r = 64'(v);
		end
		return r;
	endfunction

endpackage

// ===== rtl/uvpd_front.sv =====
// Front end: determinants, plane selection and Cramer numerators over six stages.
// Depends on uvpd_pkg.
module uvpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  uvpd_pkg::in_beat_t in_data,
	output logic              out_valid,
	output uvpd_pkg::solve_t  out_data
);

	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	uvpd_pkg::in_beat_t  in_s1, in_s2, in_s3;
	logic signed [63:0]  prod_s1 [0:5];
	logic signed [63:0]  det_s2 [0:2];
	logic signed [63:0]  det_s3 [0:2];
	logic [63:0]         mag_s3 [0:2];

	// Selected plane operands.
	logic signed [31:0]  pa0_s4, pa1_s4, ua0_s4, ua1_s4, va0_s4, va1_s4;
	logic signed [63:0]  den_s4, den_s5;
	uvpd_pkg::plane_t    plane_s4, plane_s5;
	logic signed [63:0]  nprod_s5 [0:3];
	uvpd_pkg::solve_t    sol_s6;

	// Plane selection logic.
	logic                gt01, gt02, gt12, gt10, gt20, gt21;
	uvpd_pkg::plane_t    plane_sel;
	logic signed [31:0]  pa0, pa1, ua0, ua1, va0, va1;
	logic signed [63:0]  den_sel;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: the six tangent cross products.
	always_ff @(posedge clk) begin
		if (en) begin
			in_s1      <= in_data;
			prod_s1[0] <= uvpd_pkg::smul(in_data.u_tangent_x, in_data.v_tangent_y);
			prod_s1[1] <= uvpd_pkg::smul(in_data.v_tangent_x, in_data.u_tangent_y);
			prod_s1[2] <= uvpd_pkg::smul(in_data.u_tangent_x, in_data.v_tangent_z);
			prod_s1[3] <= uvpd_pkg::smul(in_data.v_tangent_x, in_data.u_tangent_z);
			prod_s1[4] <= uvpd_pkg::smul(in_data.u_tangent_y, in_data.v_tangent_z);
			prod_s1[5] <= uvpd_pkg::smul(in_data.v_tangent_y, in_data.u_tangent_z);
		end
	end

	// Stage 2: determinants of the XY, XZ and YZ projections.
	always_ff @(posedge clk) begin
		if (en) begin
			in_s2     <= in_s1;
			det_s2[0] <= prod_s1[0] - prod_s1[1];
			det_s2[1] <= prod_s1[2] - prod_s1[3];
			det_s2[2] <= prod_s1[4] - prod_s1[5];
		end
	end

	// Stage 3: determinant magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			in_s3     <= in_s2;
			det_s3[0] <= det_s2[0];
			det_s3[1] <= det_s2[1];
			det_s3[2] <= det_s2[2];
			mag_s3[0] <= uvpd_pkg::mag64(det_s2[0]);
			mag_s3[1] <= uvpd_pkg::mag64(det_s2[1]);
			mag_s3[2] <= uvpd_pkg::mag64(det_s2[2]);
		end
	end

	// Pick the plane with a strictly greatest nonzero magnitude and its operands.
	always_comb begin
		gt01 = mag_s3[0] > mag_s3[1];
		gt02 = mag_s3[0] > mag_s3[2];
		gt12 = mag_s3[1] > mag_s3[2];
		gt10 = mag_s3[1] > mag_s3[0];
		gt20 = mag_s3[2] > mag_s3[0];
		gt21 = mag_s3[2] > mag_s3[1];
		if (gt01 && gt02) begin
			plane_sel = uvpd_pkg::PLANE_XY;
		end else if (gt10 && gt12) begin
			plane_sel = uvpd_pkg::PLANE_XZ;
		end else if (gt20 && gt21) begin
			plane_sel = uvpd_pkg::PLANE_YZ;
		end else begin
			plane_sel = uvpd_pkg::PLANE_NONE;
		end
		case (plane_sel)
			uvpd_pkg::PLANE_XY: begin
				pa0 = in_s3.delta_x;      pa1 = in_s3.delta_y;
				ua0 = in_s3.u_tangent_x;  ua1 = in_s3.u_tangent_y;
				va0 = in_s3.v_tangent_x;  va1 = in_s3.v_tangent_y;
				den_sel = det_s3[0];
			end
			uvpd_pkg::PLANE_XZ: begin
				pa0 = in_s3.delta_x;      pa1 = in_s3.delta_z;
				ua0 = in_s3.u_tangent_x;  ua1 = in_s3.u_tangent_z;
				va0 = in_s3.v_tangent_x;  va1 = in_s3.v_tangent_z;
				den_sel = det_s3[1];
			end
			uvpd_pkg::PLANE_YZ: begin
				pa0 = in_s3.delta_y;      pa1 = in_s3.delta_z;
				ua0 = in_s3.u_tangent_y;  ua1 = in_s3.u_tangent_z;
				va0 = in_s3.v_tangent_y;  va1 = in_s3.v_tangent_z;
				den_sel = det_s3[2];
			end
			default: begin
				// No usable plane: the result is forced to zero later, keep the divisor nonzero.
				pa0 = 32'sd0; pa1 = 32'sd0;
				ua0 = 32'sd0; ua1 = 32'sd0;
				va0 = 32'sd0; va1 = 32'sd0;
				den_sel = 64'sd1;
			end
		endcase
	end

	// Stage 4: selected operands.
	always_ff @(posedge clk) begin
		if (en) begin
			pa0_s4   <= pa0;
			pa1_s4   <= pa1;
			ua0_s4   <= ua0;
			ua1_s4   <= ua1;
			va0_s4   <= va0;
			va1_s4   <= va1;
			den_s4   <= den_sel;
			plane_s4 <= plane_sel;
		end
	end

	// Stage 5: numerator products.
	always_ff @(posedge clk) begin
		if (en) begin
			nprod_s5[0] <= uvpd_pkg::smul(pa0_s4, va1_s4);
			nprod_s5[1] <= uvpd_pkg::smul(va0_s4, pa1_s4);
			nprod_s5[2] <= uvpd_pkg::smul(ua0_s4, pa1_s4);
			nprod_s5[3] <= uvpd_pkg::smul(pa0_s4, ua1_s4);
			den_s5      <= den_s4;
			plane_s5    <= plane_s4;
		end
	end

	// Stage 6: Cramer numerators.
	always_ff @(posedge clk) begin
		if (en) begin
			sol_s6.num_u <= nprod_s5[0] - nprod_s5[1];
			sol_s6.num_v <= nprod_s5[2] - nprod_s5[3];
			sol_s6.den   <= den_s5;
			sol_s6.plane <= plane_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = sol_s6;

endmodule

// ===== rtl/uvpd_div.sv =====
// Pipelined restoring divider for both quotients, one quotient bit per stage, with saturation.
// Depends on uvpd_pkg.
module uvpd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  uvpd_pkg::solve_t   in_data,
	output logic               out_valid,
	output uvpd_pkg::out_beat_t out_data
);

	localparam int NSTEP = uvpd_pkg::QUO_BITS;

	// Magnitude stage.
	logic                v_s1;
	logic [63:0]         nu_s1, nv_s1, dm_s1;
	logic                negu_s1, negv_s1;
	uvpd_pkg::plane_t    plane_s1;

	// Step stages: index 0 is the setup stage, index k+1 follows step k.
	logic                v_sk     [0:NSTEP];
	uvpd_pkg::lane_t     lu_sk    [0:NSTEP];
	uvpd_pkg::lane_t     lv_sk    [0:NSTEP];
	logic [63:0]         dm_sk    [0:NSTEP];
	uvpd_pkg::plane_t    plane_sk [0:NSTEP];

	// Output stage.
	logic                v_so;
	uvpd_pkg::out_beat_t res_so;

	// Set up a lane: first partial remainder, overflow check, bits still to shift in.
	function automatic uvpd_pkg::lane_t lane_init(logic [63:0] n, logic [63:0] d, logic neg);
		uvpd_pkg::lane_t l;
		logic [63:0]     r0;
		r0 = n >> uvpd_pkg::PRE_SHIFT;
		l.ovf  = r0 >= d;
		l.rem  = l.ovf ? 64'd0 : r0;
		l.bits = {n[uvpd_pkg::PRE_SHIFT-1:0], uvpd_pkg::FRAC_BITS'(0)};
		l.quo  = '0;
		l.neg  = neg;
		return l;
	endfunction

	// One restoring step: shift in a bit, subtract when the divisor fits.
	function automatic uvpd_pkg::lane_t lane_step(uvpd_pkg::lane_t l, logic [63:0] d);
		uvpd_pkg::lane_t o;
		logic [64:0]     t;
		logic [64:0]     diff;
		logic            ge;
		t    = {l.rem, l.bits[uvpd_pkg::QUO_BITS-1]};
		diff = t - {1'b0, d};
		ge   = t >= {1'b0, d};
		o      = l;
		o.rem  = ge ? diff[63:0] : t[63:0];
		o.bits = {l.bits[uvpd_pkg::QUO_BITS-2:0], 1'b0};
		o.quo  = {l.quo[uvpd_pkg::QUO_BITS-2:0], ge};
		return o;
	endfunction

	// Apply sign and saturate to 32 bits.
	function automatic logic signed [31:0] lane_sat(uvpd_pkg::lane_t l);
		logic signed [31:0] r;
		if (l.neg) begin
			if (l.ovf || (l.quo > 32'h8000_0000)) begin
				r = 32'sh8000_0000;
			end else begin
				r = 32'(32'd0 - l.quo);
			end
		end else begin
			if (l.ovf || l.quo[31]) begin
				r = 32'sh7FFF_FFFF;
			end else begin
				r = 32'(l.quo);
			end
		end
		return r;
	endfunction

	// Valid bits for every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_so <= 1'b0;
			for (int k = 0; k <= NSTEP; k++) begin
				v_sk[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= in_valid;
			v_sk[0] <= v_s1;
			for (int k = 0; k < NSTEP; k++) begin
				v_sk[k+1] <= v_sk[k];
			end
			v_so <= v_sk[NSTEP];
		end
	end

	// Magnitudes and result signs.
	always_ff @(posedge clk) begin
		if (en) begin
			nu_s1    <= uvpd_pkg::mag64(in_data.num_u);
			nv_s1    <= uvpd_pkg::mag64(in_data.num_v);
			dm_s1    <= uvpd_pkg::mag64(in_data.den);
			negu_s1  <= in_data.num_u[63] ^ in_data.den[63];
			negv_s1  <= in_data.num_v[63] ^ in_data.den[63];
			plane_s1 <= in_data.plane;
		end
	end

	// Setup stage.
	always_ff @(posedge clk) begin
		if (en) begin
			lu_sk[0]    <= lane_init(nu_s1, dm_s1, negu_s1);
			lv_sk[0]    <= lane_init(nv_s1, dm_s1, negv_s1);
			dm_sk[0]    <= dm_s1;
			plane_sk[0] <= plane_s1;
		end
	end

	// Quotient bit stages.
	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				lu_sk[k+1]    <= lane_step(lu_sk[k], dm_sk[k]);
				lv_sk[k+1]    <= lane_step(lv_sk[k], dm_sk[k]);
				dm_sk[k+1]    <= dm_sk[k];
				plane_sk[k+1] <= plane_sk[k];
			end
		end
	end

	// Output stage: saturate, and zero everything when no plane was usable.
	always_ff @(posedge clk) begin
		if (en) begin
			if (plane_sk[NSTEP] == uvpd_pkg::PLANE_NONE) begin
				res_so.u_change <= 32'sd0;
				res_so.v_change <= 32'sd0;
			end else begin
				res_so.u_change <= lane_sat(lu_sk[NSTEP]);
				res_so.v_change <= lane_sat(lv_sk[NSTEP]);
			end
			res_so.plane_used <= plane_sk[NSTEP];
		end
	end

	assign out_valid = v_so;
	assign out_data  = res_so;

endmodule

// ===== rtl/uv_from_point_differentials.sv =====
// A beat passes the front-end stages, then divider magnitude, setup, step and output stages.
// Throughput: one beat per cycle unless stalled; the 32-step divider is fully pipelined.
// The whole pipeline advances together; it holds while the output register is full and stalled.
// Reset: arst_n clears all valid bits asynchronously; payload registers are not reset.
// Depends on uvpd_pkg, uvpd_front and uvpd_div.
module uv_from_point_differentials (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  uvpd_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output uvpd_pkg::out_beat_t out_data
);

	logic             en;
	logic             front_valid;
	uvpd_pkg::solve_t front_data;

	// Advance when the output register is empty or being drained.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	uvpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.out_valid (front_valid),
		.out_data  (front_data)
	);

	uvpd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.in_data   (front_data),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
